FILE: sv/gol_pkg.sv
// Shared types and constants for the life cellular automaton grid.
package gol_pkg;

    // Item kind codes
    localparam logic [1:0] KIND_TOGGLE = 2'd0;
    localparam logic [1:0] KIND_STEP   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     GRID_DIM_RESET  = 7'd64;

    // Rule B3/S23
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_LOW = 4'd2;

    // Field widths
    localparam int COORD_W = 6;
    localparam int COUNT_W = 4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
    } item_t;

    typedef struct packed {
        logic               cell_alive;
        logic [COUNT_W-1:0] neighbour_count;
    } result_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP_RD0,
        ST_STEP_RD1,
        ST_STEP_RD2,
        ST_CELL,
        ST_ROW_END,
        ST_TOG_RD,
        ST_TOG_WR,
        ST_RPT_RD0,
        ST_RPT_RD1,
        ST_RPT_RD2,
        ST_RPT_RD3,
        ST_RPT_OUT
    } state_t;

endpackage

FILE: sv/life_cellular_automaton_grid_top.sv
// Top level of the life cellular automaton grid (rule B3/S23, no wrap).
//
// The grid lives in a RAM of MAX_ROWS rows, each MAX_COLUMNS bits wide. After
// reset a clearing pass writes every row to dead, one row a cycle, so busy stays
// high until the pass ends, before the first item is taken. An item is taken when
// start is high and busy low; busy then stays high until its result has been
// put out. The single result is shown for one cycle with done high and cannot
// be held off. A read gathers the addressed cell's three-row window by reading
// rows cy-1, cy and cy+1; a toggle first does a read-modify-write of row cy and
// then gathers the same window. In a step over an active area of w columns by
// h rows, one shared neighbour-count and rule unit visits one cell per cycle,
// and a row-end state writes each new row back. Toggles and reads addressing
// outside the active area skip the RAM reads and return zeros; a step
// addressing outside still sweeps the grid first and then returns zeros.
module life_cellular_automaton_grid_top #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  gol_pkg::item_t                     item,
    output logic                               done,
    output gol_pkg::result_t                   result,
    input  logic                               cfg_write,
    input  logic [gol_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gol_pkg::CFG_W-1:0]          cfg_data
);

    localparam int XW      = $clog2(MAX_COLUMNS);
    localparam int YW      = $clog2(MAX_ROWS);
    localparam int DIM_MAX = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int CW0     = $clog2(DIM_MAX + 3);
    localparam int CW      = (CW0 > gol_pkg::CFG_W) ? CW0 : gol_pkg::CFG_W;

    // Control registers
    gol_pkg::state_t            state_reg, state_next;
    logic [XW-1:0]              x_reg, x_next;
    logic [YW-1:0]              y_reg, y_next;
    logic                       done_reg, done_next;
    logic [gol_pkg::CFG_W-1:0]  grid_width_reg, grid_height_reg;

    // Payload registers
    gol_pkg::item_t             item_reg, item_next;
    gol_pkg::result_t           result_reg, result_next;
    logic [MAX_COLUMNS-1:0]     prev_row_reg, prev_row_next;
    logic [MAX_COLUMNS-1:0]     cur_row_reg, cur_row_next;
    logic [MAX_COLUMNS-1:0]     nxt_row_reg, nxt_row_next;
    logic [MAX_COLUMNS-1:0]     new_row_reg, new_row_next;

    // RAM port
    logic                       ram_we, ram_re;
    logic [YW-1:0]              ram_waddr, ram_raddr;
    logic [MAX_COLUMNS-1:0]     ram_wdata, ram_rdata;

    // Active area and addressed cell
    logic [CW-1:0]              wd_ext, ht_ext, w_act, h_act;
    logic [CW-1:0]              cx_ext, cy_ext, x_ext, y_ext;
    logic                       in_area;
    logic [XW-1:0]              cx;
    logic [YW-1:0]              cy;

    // Shared count unit
    logic [XW-1:0]              col, col_l, col_r;
    logic                       left_ok, right_ok;
    logic                       centre;
    logic [gol_pkg::COUNT_W-1:0] ncount;
    logic                       rule_bit;

    gol_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Active dimensions: zero acts as one, too large saturates
    always_comb
    begin
        wd_ext = CW'(grid_width_reg);
        ht_ext = CW'(grid_height_reg);
        if (wd_ext == '0)
            w_act = CW'(1);
        else if (wd_ext > CW'(MAX_COLUMNS))
            w_act = CW'(MAX_COLUMNS);
        else
            w_act = wd_ext;
        if (ht_ext == '0)
            h_act = CW'(1);
        else if (ht_ext > CW'(MAX_ROWS))
            h_act = CW'(MAX_ROWS);
        else
            h_act = ht_ext;
    end

    assign cx_ext  = CW'(item_reg.cell_x);
    assign cy_ext  = CW'(item_reg.cell_y);
    assign x_ext   = CW'(x_reg);
    assign y_ext   = CW'(y_reg);
    assign in_area = (cx_ext < w_act) && (cy_ext < h_act);
    assign cx      = XW'(item_reg.cell_x);
    assign cy      = YW'(item_reg.cell_y);

    // Neighbour count over the three-row window at one column
    always_comb
    begin
        col      = (state_reg == gol_pkg::ST_CELL) ? x_reg : cx;
        col_l    = (col == '0) ? col : col - XW'(1);
        col_r    = (col == XW'(MAX_COLUMNS - 1)) ? col : col + XW'(1);
        left_ok  = (col != '0);
        right_ok = ((CW'(col) + CW'(1)) < w_act);
        centre   = cur_row_reg[col];
        ncount   = gol_pkg::COUNT_W'(prev_row_reg[col])
                 + gol_pkg::COUNT_W'(nxt_row_reg[col])
                 + gol_pkg::COUNT_W'(left_ok  & prev_row_reg[col_l])
                 + gol_pkg::COUNT_W'(left_ok  & cur_row_reg[col_l])
                 + gol_pkg::COUNT_W'(left_ok  & nxt_row_reg[col_l])
                 + gol_pkg::COUNT_W'(right_ok & prev_row_reg[col_r])
                 + gol_pkg::COUNT_W'(right_ok & cur_row_reg[col_r])
                 + gol_pkg::COUNT_W'(right_ok & nxt_row_reg[col_r]);
        if (ncount == gol_pkg::BIRTH_COUNT)
            rule_bit = 1'b1;
        else if (ncount == gol_pkg::SURVIVE_LOW)
            rule_bit = centre;
        else
            rule_bit = 1'b0;
    end

    // Sequencer: next state, datapath updates and RAM control
    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        done_next     = 1'b0;
        item_next     = item_reg;
        result_next   = result_reg;
        prev_row_next = prev_row_reg;
        cur_row_next  = cur_row_reg;
        nxt_row_next  = nxt_row_reg;
        new_row_next  = new_row_reg;
        ram_we        = 1'b0;
        ram_waddr     = y_reg;
        ram_wdata     = new_row_reg;
        ram_re        = 1'b0;
        ram_raddr     = cy;

        unique case (state_reg)
            gol_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (y_reg == YW'(MAX_ROWS - 1))
                begin
                    y_next     = '0;
                    state_next = gol_pkg::ST_IDLE;
                end
                else
                begin
                    y_next = y_reg + YW'(1);
                end
            end

            gol_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    if (item.kind == gol_pkg::KIND_STEP)
                        state_next = gol_pkg::ST_STEP_RD0;
                    else if ((CW'(item.cell_x) >= w_act) || (CW'(item.cell_y) >= h_act))
                        state_next = gol_pkg::ST_RPT_OUT;
                    else if (item.kind == gol_pkg::KIND_TOGGLE)
                        state_next = gol_pkg::ST_TOG_RD;
                    else
                        state_next = gol_pkg::ST_RPT_RD0;
                end
            end

            // Step: load rows 0 and 1 into the window
            gol_pkg::ST_STEP_RD0:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = gol_pkg::ST_STEP_RD1;
            end

            gol_pkg::ST_STEP_RD1:
            begin
                cur_row_next  = ram_rdata;
                new_row_next  = ram_rdata;
                prev_row_next = '0;
                y_next        = '0;
                ram_re        = (h_act > CW'(1));
                ram_raddr     = YW'(1);
                state_next    = gol_pkg::ST_STEP_RD2;
            end

            gol_pkg::ST_STEP_RD2:
            begin
                nxt_row_next = (h_act > CW'(1)) ? ram_rdata : '0;
                x_next       = '0;
                state_next   = gol_pkg::ST_CELL;
            end

            // One cell per cycle; fetch the row after the window on the first
            gol_pkg::ST_CELL:
            begin
                new_row_next[x_reg] = rule_bit;
                if (x_reg == '0)
                begin
                    ram_re    = ((y_ext + CW'(2)) < h_act);
                    ram_raddr = y_reg + YW'(2);
                end
                if ((x_ext + CW'(1)) == w_act)
                    state_next = gol_pkg::ST_ROW_END;
                else
                    x_next = x_reg + XW'(1);
            end

            // Write the new row back and slide the window down
            gol_pkg::ST_ROW_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = y_reg;
                ram_wdata = new_row_reg;
                if ((y_ext + CW'(1)) == h_act)
                begin
                    state_next = in_area ? gol_pkg::ST_RPT_RD0 : gol_pkg::ST_RPT_OUT;
                end
                else
                begin
                    prev_row_next = cur_row_reg;
                    cur_row_next  = nxt_row_reg;
                    new_row_next  = nxt_row_reg;
                    nxt_row_next  = ((y_ext + CW'(2)) < h_act) ? ram_rdata : '0;
                    y_next        = y_reg + YW'(1);
                    x_next        = '0;
                    state_next    = gol_pkg::ST_CELL;
                end
            end

            // Toggle: read-modify-write of the addressed row
            gol_pkg::ST_TOG_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = cy;
                state_next = gol_pkg::ST_TOG_WR;
            end

            gol_pkg::ST_TOG_WR:
            begin
                ram_we           = 1'b1;
                ram_waddr        = cy;
                ram_wdata        = ram_rdata;
                ram_wdata[cx]    = ~ram_rdata[cx];
                state_next       = gol_pkg::ST_RPT_RD0;
            end

            // Report: gather rows cy-1, cy, cy+1
            gol_pkg::ST_RPT_RD0:
            begin
                ram_re     = (cy != '0);
                ram_raddr  = cy - YW'(1);
                state_next = gol_pkg::ST_RPT_RD1;
            end

            gol_pkg::ST_RPT_RD1:
            begin
                prev_row_next = (cy != '0) ? ram_rdata : '0;
                ram_re        = 1'b1;
                ram_raddr     = cy;
                state_next    = gol_pkg::ST_RPT_RD2;
            end

            gol_pkg::ST_RPT_RD2:
            begin
                cur_row_next = ram_rdata;
                ram_re       = ((cy_ext + CW'(1)) < h_act);
                ram_raddr    = cy + YW'(1);
                state_next   = gol_pkg::ST_RPT_RD3;
            end

            gol_pkg::ST_RPT_RD3:
            begin
                nxt_row_next = ((cy_ext + CW'(1)) < h_act) ? ram_rdata : '0;
                state_next   = gol_pkg::ST_RPT_OUT;
            end

            gol_pkg::ST_RPT_OUT:
            begin
                done_next = 1'b1;
                if (in_area)
                begin
                    result_next.cell_alive      = centre;
                    result_next.neighbour_count = ncount;
                end
                else
                begin
                    result_next.cell_alive      = 1'b0;
                    result_next.neighbour_count = '0;
                end
                state_next = gol_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = gol_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gol_pkg::ST_CLEAR;
            x_reg     <= '0;
            y_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            done_reg  <= done_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= gol_pkg::GRID_DIM_RESET;
            grid_height_reg <= gol_pkg::GRID_DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gol_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                gol_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Payload: item, result and the row window
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        result_reg   <= result_next;
        prev_row_reg <= prev_row_next;
        cur_row_reg  <= cur_row_next;
        nxt_row_reg  <= nxt_row_next;
        new_row_reg  <= new_row_next;
    end

    assign busy   = (state_reg != gol_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sv/gol_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gol_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
